[rtl/vgmpsg_pkg.sv]
// Shared types and constants for the VGM to PSG stream converter.
package vgmpsg_pkg;

  localparam int ADDR_BITS_DEFAULT = 16;

  // VGM command codes
  localparam logic [7:0] CMD_GG_STEREO = 8'h4F;
  localparam logic [7:0] CMD_PSG_WRITE = 8'h50;
  localparam logic [7:0] CMD_WAIT_LONG = 8'h61;
  localparam logic [7:0] CMD_WAIT_60HZ = 8'h62;
  localparam logic [7:0] CMD_WAIT_50HZ = 8'h63;
  localparam logic [7:0] CMD_END       = 8'h66;

  // output stream codes
  localparam logic [7:0] OUT_WAIT_BASE = 8'h40;
  localparam logic [7:0] OUT_END       = 8'h60;
  localparam logic [7:0] PSG_DATA_MASK = 8'h3F;

  // header layout
  localparam logic [6:0]  HEADER_LAST      = 7'd63;
  localparam logic [6:0]  LOOP_FIELD_FIRST = 7'h1C;
  localparam logic [6:0]  LOOP_FIELD_LAST  = 7'h1F;
  localparam logic [31:0] LOOP_BIAS        = 32'h0000_0040 - 32'h0000_001C;

  localparam logic [3:0] WAIT_RUN_MAX = 4'hF;

  // samples / 17 as multiply by ceil(2^20 / 17), then >> 20 (exact for 16-bit input)
  localparam logic [15:0] DIV17_RECIP = 16'd61681;
  localparam int          DIV17_SHIFT = 20;

  localparam int POS_RESET = 2;

  // result queue: one input byte makes at most MAX_WORDS words
  localparam int MAX_WORDS  = 4;
  localparam int FIFO_DEPTH = 8;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] out_addr;
    logic        out_overflow;
    logic        out_final;
  } out_t;

endpackage

[rtl/vgm_to_psg_stream_converter_top.sv]
// VGM byte stream to PSG command stream converter, top level.
//
//   channel | handshake            | payload                     | word
//   --------+----------------------+-----------------------------+--------------------------
//   in      | in_valid / in_ready  | in_data  (vgmpsg_pkg::in_t) | one VGM file byte
//   out     | out_valid / out_ready| out_data (vgmpsg_pkg::out_t)| one addressed output byte
//
// Each accepted byte is decoded in the cycle it arrives and its zero to four
// words are pushed into an 8-deep queue, which drains one word per cycle while
// out_ready is high. Sustained rate is one byte per cycle while each byte yields
// at most one word and out_ready stays high. in_ready drops while the queue
// holds more than four words. Synchronous reset, no clearing pass: the block
// takes bytes from the first cycle after reset. After the end word the block
// swallows input.
module vgm_to_psg_stream_converter_top #(
  parameter int ADDR_BITS = vgmpsg_pkg::ADDR_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  vgmpsg_pkg::in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output vgmpsg_pkg::out_t out_data
);

  localparam int POS_W   = ADDR_BITS + 1;
  localparam int PTR_W   = $clog2(vgmpsg_pkg::FIFO_DEPTH);
  localparam int CNT_W   = PTR_W + 1;
  localparam logic [POS_W-1:0] CAP = POS_W'(1) << ADDR_BITS;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CMD,
    PH_STEREO,
    PH_PSG,
    PH_LONG_LO,
    PH_LONG_HI,
    PH_DONE
  } phase_t;

  // parser state
  phase_t           phase, phase_next;
  logic [6:0]       header_count, header_count_next;
  logic [31:0]      loop_offset, loop_offset_next;
  logic [16:0]      data_offset, data_offset_next;
  logic [POS_W-1:0] out_position, out_position_next;
  logic [7:0]       low_wait_byte, low_wait_byte_next;
  logic             wait_pending, wait_pending_next;
  logic [3:0]       wait_run_count, wait_run_count_next;

  // result queue
  vgmpsg_pkg::out_t fifo_mem [vgmpsg_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] head, tail;
  logic [CNT_W-1:0] count;

  logic       accept, pop;
  logic [7:0] b;
  logic       is_frame_wait;
  logic [3:0] run_inc;
  logic [31:0] div_prod;
  logic [4:0]  div_quot;
  logic        loop_hit;

  // word sources, in emission order
  logic       a_en, loop_en, c_en, d_en, fin_en, fin_cmd;
  logic [7:0] a_byte, c_byte, d_byte;
  logic [1:0] off_c, off_d, off_e, emit_total;
  logic [1:0] off_loop;

  // output positions at offsets 0..3 from the current position
  logic [POS_W-1:0]  psum [4];
  logic [POS_W-1:0]  psat [4];
  logic [POS_W+15:0] pext [4];
  logic [15:0]       p16  [4];
  logic [3:0]        povf;

  vgmpsg_pkg::out_t slot [vgmpsg_pkg::MAX_WORDS];
  logic [2:0]       slot_cnt;

  function automatic vgmpsg_pkg::out_t mk_word(input logic [7:0] byt,
                                               input logic [15:0] addr,
                                               input logic ovf,
                                               input logic fin);
    vgmpsg_pkg::out_t w;
    w.out_byte     = byt;
    w.out_addr     = addr;
    w.out_overflow = ovf;
    w.out_final    = fin;
    return w;
  endfunction

  assign b             = in_data.in_byte;
  assign is_frame_wait = (b == vgmpsg_pkg::CMD_WAIT_60HZ) || (b == vgmpsg_pkg::CMD_WAIT_50HZ);
  assign run_inc       = wait_run_count + 4'd1;

  // long wait: samples / 17, low five bits kept
  assign div_prod = 32'({b, low_wait_byte}) * 32'(vgmpsg_pkg::DIV17_RECIP);
  assign div_quot = div_prod[vgmpsg_pkg::DIV17_SHIFT +: 5];

  assign loop_hit = ((loop_offset - vgmpsg_pkg::LOOP_BIAS) == {15'd0, data_offset});

  assign in_ready  = (count <= CNT_W'(vgmpsg_pkg::FIFO_DEPTH - vgmpsg_pkg::MAX_WORDS));
  assign accept    = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = fifo_mem[head];

  // parser next state and word sources
  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    loop_offset_next    = loop_offset;
    data_offset_next    = data_offset;
    low_wait_byte_next  = low_wait_byte;
    wait_pending_next   = wait_pending;
    wait_run_count_next = wait_run_count;
    a_en    = 1'b0;
    a_byte  = vgmpsg_pkg::OUT_WAIT_BASE;
    loop_en = 1'b0;
    c_en    = 1'b0;
    c_byte  = vgmpsg_pkg::OUT_WAIT_BASE;
    fin_cmd = 1'b0;

    unique case (phase)
      PH_HEADER: begin
        if (header_count >= vgmpsg_pkg::LOOP_FIELD_FIRST &&
            header_count <= vgmpsg_pkg::LOOP_FIELD_LAST) begin
          loop_offset_next = loop_offset | (32'(b) << {header_count[1:0], 3'b000});
        end
        header_count_next = header_count + 7'd1;
        if (header_count == vgmpsg_pkg::HEADER_LAST) begin
          phase_next = PH_CMD;
        end
      end
      PH_CMD: begin
        if (wait_pending && is_frame_wait) begin
          // merge into the running frame wait
          wait_run_count_next = run_inc;
          if (run_inc == vgmpsg_pkg::WAIT_RUN_MAX) begin
            a_en                = 1'b1;
            a_byte              = vgmpsg_pkg::OUT_WAIT_BASE | {4'd0, run_inc};
            wait_pending_next   = 1'b0;
            wait_run_count_next = 4'd0;
          end
        end else begin
          if (wait_pending) begin
            a_en                = 1'b1;
            a_byte              = vgmpsg_pkg::OUT_WAIT_BASE | {4'd0, wait_run_count};
            wait_pending_next   = 1'b0;
            wait_run_count_next = 4'd0;
          end
          loop_en = loop_hit;
          case (b) inside
            vgmpsg_pkg::CMD_GG_STEREO: phase_next = PH_STEREO;
            vgmpsg_pkg::CMD_PSG_WRITE: phase_next = PH_PSG;
            vgmpsg_pkg::CMD_WAIT_60HZ,
            vgmpsg_pkg::CMD_WAIT_50HZ: begin
              wait_pending_next   = 1'b1;
              wait_run_count_next = 4'd0;
            end
            vgmpsg_pkg::CMD_WAIT_LONG: phase_next = PH_LONG_LO;
            vgmpsg_pkg::CMD_END:       fin_cmd = 1'b1;
            default: ;
          endcase
        end
      end
      PH_STEREO: phase_next = PH_CMD;
      PH_PSG: begin
        c_en       = 1'b1;
        c_byte     = b[7] ? b : (b & vgmpsg_pkg::PSG_DATA_MASK);
        phase_next = PH_CMD;
      end
      PH_LONG_LO: begin
        low_wait_byte_next = b;
        phase_next         = PH_LONG_HI;
      end
      PH_LONG_HI: begin
        c_en       = (div_quot != 5'd0);
        c_byte     = vgmpsg_pkg::OUT_WAIT_BASE + {3'd0, div_quot};
        phase_next = PH_CMD;
      end
      PH_DONE: ;
      default: ;
    endcase

    if (phase != PH_HEADER && phase != PH_DONE) begin
      data_offset_next = data_offset + 17'd1;
    end

    // end command or last file byte: flush, end word, stop
    fin_en = (phase != PH_DONE) && (fin_cmd || in_data.in_last);
    d_en   = fin_en && wait_pending_next;
    d_byte = vgmpsg_pkg::OUT_WAIT_BASE | {4'd0, wait_run_count_next};
    if (fin_en) begin
      phase_next          = PH_DONE;
      wait_pending_next   = 1'b0;
      wait_run_count_next = 4'd0;
    end
  end

  // position arithmetic; the position never passes CAP, so bit ADDR_BITS flags overflow
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      psum[i] = out_position + POS_W'(i);
      povf[i] = psum[i][ADDR_BITS];
      psat[i] = povf[i] ? CAP : psum[i];
      pext[i] = {16'd0, psat[i]};
      p16[i]  = pext[i][15:0];
    end
  end

  assign off_loop   = {1'b0, a_en};
  assign off_c      = {1'b0, a_en};
  assign off_d      = {1'b0, a_en} + {1'b0, c_en};
  assign off_e      = off_d + {1'b0, d_en};
  assign emit_total = off_e + {1'b0, fin_en};

  always_comb begin
    out_position_next = psat[emit_total];
  end

  // pack the words of this byte in order
  always_comb begin
    slot_cnt = 3'd0;
    for (int i = 0; i < vgmpsg_pkg::MAX_WORDS; i++) begin
      slot[i] = mk_word(8'd0, 16'd0, 1'b0, 1'b0);
    end
    if (a_en) begin
      slot[slot_cnt[1:0]] = mk_word(a_byte, povf[0] ? 16'd0 : p16[0], povf[0], 1'b0);
      slot_cnt = slot_cnt + 3'd1;
    end
    if (loop_en) begin
      slot[slot_cnt[1:0]] = mk_word(p16[off_loop][7:0], 16'd0, 1'b0, 1'b0);
      slot_cnt = slot_cnt + 3'd1;
      slot[slot_cnt[1:0]] = mk_word(p16[off_loop][15:8], 16'd1, 1'b0, 1'b0);
      slot_cnt = slot_cnt + 3'd1;
    end
    if (c_en) begin
      slot[slot_cnt[1:0]] = mk_word(c_byte, povf[off_c] ? 16'd0 : p16[off_c],
                                    povf[off_c], 1'b0);
      slot_cnt = slot_cnt + 3'd1;
    end
    if (d_en) begin
      slot[slot_cnt[1:0]] = mk_word(d_byte, povf[off_d] ? 16'd0 : p16[off_d],
                                    povf[off_d], 1'b0);
      slot_cnt = slot_cnt + 3'd1;
    end
    if (fin_en) begin
      slot[slot_cnt[1:0]] = mk_word(vgmpsg_pkg::OUT_END,
                                    povf[off_e] ? 16'd0 : p16[off_e], povf[off_e], 1'b1);
      slot_cnt = slot_cnt + 3'd1;
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_count   <= 7'd0;
      loop_offset    <= 32'd0;
      data_offset    <= 17'd0;
      out_position   <= POS_W'(vgmpsg_pkg::POS_RESET);
      low_wait_byte  <= 8'd0;
      wait_pending   <= 1'b0;
      wait_run_count <= 4'd0;
    end else if (accept) begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      loop_offset    <= loop_offset_next;
      data_offset    <= data_offset_next;
      out_position   <= out_position_next;
      low_wait_byte  <= low_wait_byte_next;
      wait_pending   <= wait_pending_next;
      wait_run_count <= wait_run_count_next;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < vgmpsg_pkg::MAX_WORDS; i++) begin
        if (3'(i) < slot_cnt) begin
          fifo_mem[tail + PTR_W'(i)] <= slot[i];
        end
      end
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (accept) begin
        tail <= tail + PTR_W'(slot_cnt);
      end
      if (pop) begin
        head <= head + PTR_W'(1);
      end
      count <= count + (accept ? CNT_W'(slot_cnt) : CNT_W'(0)) - (pop ? CNT_W'(1) : CNT_W'(0));
    end
  end

endmodule

[tb/vgm_to_psg_stream_converter_top_test.sv]
// Self-checking test of the VGM to PSG stream converter: one file streamed through.
`timescale 1ns / 1ps

module vgm_to_psg_stream_converter_top_test;

  localparam int HALF_PERIOD   = 4;
  localparam int CAPACITY      = 1 << vgmpsg_pkg::ADDR_BITS_DEFAULT;
  localparam int HEADER_BYTES  = int'(vgmpsg_pkg::HEADER_LAST) + 1;
  localparam int LONG_WAIT_DIV = 882 / 50;     // samples per output wait step
  localparam int DATA_OFS_BITS = 17;
  localparam logic [7:0] SHORT_WAIT_FIRST = 8'h70;
  localparam logic [7:0] SHORT_WAIT_LAST  = 8'h7F;
  // data offset of the first long wait in the directed run; the loop point sits there
  localparam int LOOP_CMD_OFS  = 13;
  localparam int MAX_REPORTS   = 10;
  localparam int TAIL_CYCLES   = 2 * vgmpsg_pkg::FIFO_DEPTH + 4;
  // bound on the whole run; reaching it ends the test with mismatches reported
  localparam int CYCLE_LIMIT   = 100_000;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_COMMAND,
    ST_STEREO_ARG,
    ST_PSG_ARG,
    ST_WAIT_LO,
    ST_WAIT_HI,
    ST_DONE
  } conv_state_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  vgmpsg_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  vgmpsg_pkg::out_t out_data;

  vgm_to_psg_stream_converter_top #(
    .ADDR_BITS(vgmpsg_pkg::ADDR_BITS_DEFAULT)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Converter model state, as it stands after reset.
  // ---------------------------------------------------------------------------
  conv_state_t              conv_state = ST_HEADER;
  int unsigned              hdr_count  = 0;
  logic [31:0]              loop_ofs   = '0;
  logic [DATA_OFS_BITS-1:0] data_ofs   = '0;
  int unsigned              out_pos    = vgmpsg_pkg::POS_RESET;
  logic [7:0]               wait_lo    = '0;
  logic                     wait_held  = 1'b0;
  int unsigned              wait_run   = 0;
  logic                     conv_done  = 1'b0;

  vgmpsg_pkg::out_t due_words[$];     // words the block still owes, oldest first
  vgmpsg_pkg::out_t head_word;

  int idle_pct       = 0;   // sender: chance in a hundred of an idle cycle
  int stall_pct      = 0;   // receiver: chance in a hundred of holding off
  int mismatch_count = 0;
  int cycle_count    = 0;

  function automatic void push_word(logic [7:0] b, logic [15:0] a, logic ovf, logic fin);
    vgmpsg_pkg::out_t w;
    w.out_byte     = b;
    w.out_addr     = a;
    w.out_overflow = ovf;
    w.out_final    = fin;
    due_words.push_back(w);
  endfunction

  // Buffer write: past capacity the word is still reported, flagged, at address 0,
  // and the position sticks at the capacity.
  function automatic void emit_word(logic [7:0] b, logic fin);
    if (out_pos >= CAPACITY) begin
      out_pos = CAPACITY;
      push_word(b, 16'd0, 1'b1, fin);
    end else begin
      push_word(b, 16'(out_pos), 1'b0, fin);
      out_pos++;
    end
  endfunction

  function automatic void flush_wait();
    if (wait_held) begin
      emit_word(vgmpsg_pkg::OUT_WAIT_BASE + 8'(wait_run), 1'b0);
      wait_held = 1'b0;
      wait_run  = 0;
    end
  endfunction

  function automatic void close_stream();
    flush_wait();
    emit_word(vgmpsg_pkg::OUT_END, 1'b1);
    conv_done  = 1'b1;
    conv_state = ST_DONE;
  endfunction

  function automatic void begin_command(logic [7:0] b);
    // loop point: low then high byte of the position, to addresses 0 and 1
    if (loop_ofs - vgmpsg_pkg::LOOP_BIAS == 32'(data_ofs)) begin
      push_word(8'(out_pos), 16'd0, 1'b0, 1'b0);
      push_word(8'(out_pos >> 8), 16'd1, 1'b0, 1'b0);
    end
    case (b) inside
      vgmpsg_pkg::CMD_GG_STEREO: conv_state = ST_STEREO_ARG;
      vgmpsg_pkg::CMD_PSG_WRITE: conv_state = ST_PSG_ARG;
      vgmpsg_pkg::CMD_WAIT_60HZ, vgmpsg_pkg::CMD_WAIT_50HZ: begin
        wait_held = 1'b1;
        wait_run  = 0;
      end
      vgmpsg_pkg::CMD_WAIT_LONG: conv_state = ST_WAIT_LO;
      vgmpsg_pkg::CMD_END:       close_stream();
      default:                   ;   // short waits and unknown codes
    endcase
  endfunction

  // Works out the words that one accepted file byte causes.
  function automatic void convert_vgm_byte(vgmpsg_pkg::in_t item);
    logic [7:0]  b;
    int unsigned samples;
    int unsigned steps;
    b = item.in_byte;
    if (conv_done) return;
    if (conv_state == ST_HEADER) begin
      if (hdr_count >= vgmpsg_pkg::LOOP_FIELD_FIRST && hdr_count <= vgmpsg_pkg::LOOP_FIELD_LAST)
        loop_ofs = loop_ofs | (32'(b) << (8 * (hdr_count - vgmpsg_pkg::LOOP_FIELD_FIRST)));
      hdr_count++;
      if (hdr_count >= HEADER_BYTES) begin
        hdr_count  = HEADER_BYTES;
        conv_state = ST_COMMAND;
      end
    end else begin
      case (conv_state)
        ST_COMMAND: begin
          // a frame wait joining a run is no command start
          if (wait_held && (b == vgmpsg_pkg::CMD_WAIT_60HZ ||
                            b == vgmpsg_pkg::CMD_WAIT_50HZ)) begin
            wait_run++;
            if (wait_run >= vgmpsg_pkg::WAIT_RUN_MAX) flush_wait();
          end else begin
            flush_wait();
            begin_command(b);
          end
        end
        ST_STEREO_ARG: conv_state = ST_COMMAND;
        ST_PSG_ARG: begin
          emit_word(b[7] ? b : (b & vgmpsg_pkg::PSG_DATA_MASK), 1'b0);
          conv_state = ST_COMMAND;
        end
        ST_WAIT_LO: begin
          wait_lo    = b;
          conv_state = ST_WAIT_HI;
        end
        ST_WAIT_HI: begin
          samples = 32'({b, wait_lo});
          steps   = (samples / LONG_WAIT_DIV) & 32'h1F;
          if (steps != 0) emit_word(vgmpsg_pkg::OUT_WAIT_BASE + 8'(steps), 1'b0);
          conv_state = ST_COMMAND;
        end
        default: ;
      endcase
      data_ofs++;
    end
    if (item.in_last && !conv_done) close_stream();
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Tasks are entered and left just after a falling edge; valid
  // stays high between back-to-back bytes and drops only for idle cycles or a drain.
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_data.in_byte = b;
    in_data.in_last = last;
    do @(posedge clk); while (!in_ready);
    convert_vgm_byte(in_data);
    @(negedge clk);
  endtask

  // File body byte: the end code is kept out of command position until the end test.
  task automatic send_cmd_byte(logic [7:0] b);
    if (conv_state == ST_COMMAND && b == vgmpsg_pkg::CMD_END)
      b = vgmpsg_pkg::CMD_END + 8'd1;
    send_byte(b, 1'b0);
  endtask

  // Hold the input off until every owed word has come out.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (due_words.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure and the word checker.
  // ---------------------------------------------------------------------------
  always @(negedge clk) out_ready = ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected word: byte %h addr %h ovf %b fin %b",
                   out_data.out_byte, out_data.out_addr, out_data.out_overflow,
                   out_data.out_final);
      end else begin
        head_word = due_words.pop_front();
        if (out_data.out_byte     !== head_word.out_byte     ||
            out_data.out_addr     !== head_word.out_addr     ||
            out_data.out_overflow !== head_word.out_overflow ||
            out_data.out_final    !== head_word.out_final) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"word mismatch: expected byte %h addr %h ovf %b fin %b, ",
                      "got byte %h addr %h ovf %b fin %b"},
                     head_word.out_byte, head_word.out_addr, head_word.out_overflow,
                     head_word.out_final, out_data.out_byte, out_data.out_addr,
                     out_data.out_overflow, out_data.out_final);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests. There is one reset, so the whole run is a single file: header,
  // directed commands, random body, then the end of file and input after it.
  // ---------------------------------------------------------------------------

  // 64-byte header; the loop field points at the directed long wait, or now and
  // then below the bias so that no loop point exists.
  task automatic test_header();
    logic [31:0] loop_val;
    if ($urandom_range(0, 3) == 0) loop_val = $urandom_range(0, vgmpsg_pkg::LOOP_BIAS - 1);
    else                           loop_val = vgmpsg_pkg::LOOP_BIAS + LOOP_CMD_OFS;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      if (i >= vgmpsg_pkg::LOOP_FIELD_FIRST && i <= vgmpsg_pkg::LOOP_FIELD_LAST)
        send_byte(loop_val[8 * (i - vgmpsg_pkg::LOOP_FIELD_FIRST) +: 8], 1'b0);
      else
        send_byte(8'($urandom), 1'b0);
    end
  endtask

  // Every command but the end code, data extremes, masked and unmasked PSG data, a
  // merged wait run, long waits of one step, of the largest sample count and under one step.
  task automatic test_directed();
    logic [7:0] seq [24] = '{
      vgmpsg_pkg::CMD_PSG_WRITE, 8'h00, vgmpsg_pkg::CMD_PSG_WRITE, 8'hFF,
      vgmpsg_pkg::CMD_PSG_WRITE, 8'h7F,
      vgmpsg_pkg::CMD_GG_STEREO, vgmpsg_pkg::CMD_PSG_WRITE,   // stereo eats the 0x50
      vgmpsg_pkg::CMD_WAIT_60HZ, vgmpsg_pkg::CMD_WAIT_50HZ,
      vgmpsg_pkg::CMD_WAIT_60HZ,                              // one run of three
      vgmpsg_pkg::CMD_PSG_WRITE, 8'h80,
      vgmpsg_pkg::CMD_WAIT_LONG, 8'h11, 8'h00,                // 17 samples: one step
      vgmpsg_pkg::CMD_WAIT_LONG, 8'hFF, 8'hFF,
      vgmpsg_pkg::CMD_WAIT_LONG, 8'h10, 8'h00,                // under one step: silent
      SHORT_WAIT_LAST, 8'hFF
    };
    idle_pct  = 0;
    stall_pct = 0;
    foreach (seq[i]) send_byte(seq[i], 1'b0);
  endtask

  // Mostly well-formed commands with random content; the rest raw noise.
  task automatic test_random(int n, int idle, int stall);
    int kind;
    int sent;
    int len;
    logic [7:0] code;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < n) begin
      kind = $urandom_range(0, 19);
      if (kind <= 5) begin
        send_cmd_byte(vgmpsg_pkg::CMD_PSG_WRITE);
        send_cmd_byte(8'($urandom));
        sent += 2;
      end else if (kind <= 7) begin
        send_cmd_byte(vgmpsg_pkg::CMD_GG_STEREO);
        send_cmd_byte(8'($urandom));
        sent += 2;
      end else if (kind <= 10) begin
        send_cmd_byte(vgmpsg_pkg::CMD_WAIT_LONG);
        send_cmd_byte(8'($urandom));
        send_cmd_byte(8'($urandom));
        sent += 3;
      end else if (kind <= 13) begin
        // runs past sixteen waits split into a full word and a new run
        len = $urandom_range(1, 20);
        repeat (len) begin
          code = $urandom_range(0, 1) ? vgmpsg_pkg::CMD_WAIT_60HZ : vgmpsg_pkg::CMD_WAIT_50HZ;
          send_cmd_byte(code);
        end
        sent += len;
      end else if (kind == 14) begin
        send_cmd_byte(8'($urandom_range(SHORT_WAIT_FIRST, SHORT_WAIT_LAST)));
        sent++;
      end else begin
        send_cmd_byte(8'($urandom));
        sent++;
      end
    end
  endtask

  // Pending wait, then one of: end command, a last-flagged byte, or a long wait
  // cut short by the last flag.
  task automatic test_end_of_file();
    idle_pct  = 6;
    stall_pct = 6;
    send_cmd_byte(vgmpsg_pkg::CMD_WAIT_60HZ);
    send_cmd_byte(vgmpsg_pkg::CMD_WAIT_50HZ);
    case ($urandom_range(0, 2))
      0: send_byte(vgmpsg_pkg::CMD_END, 1'($urandom));
      1: send_byte(8'($urandom), 1'b1);
      default: begin
        send_cmd_byte(vgmpsg_pkg::CMD_WAIT_LONG);
        send_byte(8'($urandom), 1'b1);
      end
    endcase
  endtask

  // Once finished, the block swallows input without a word.
  task automatic test_after_finish();
    repeat (4) send_byte(8'($urandom), 1'($urandom));
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    test_header();
    test_directed();
    test_random(40, 0, 0);
    test_random(40, 69, 0);
    wait_drained();
    test_random(40, 0, 69);
    test_random(40, 6, 6);
    wait_drained();
    test_end_of_file();
    test_after_finish();

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    mismatch_count += due_words.size();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
